### design/cps_pkg.sv
// Shared types and constants for the categorical peel selector.
// Depends on nothing; every other design file imports it.
package cps_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_ALPHA   = 2'd0;
    localparam logic [1:0] CFG_SUPPORT = 2'd1;
    localparam logic [1:0] CFG_CATS    = 2'd2;
    localparam logic [1:0] CFG_TAG     = 2'd3;

    // Register reset values
    localparam logic [16:0] ALPHA_RESET   = 17'd6554;
    localparam logic [16:0] SUPPORT_RESET = 17'd0;
    localparam logic [6:0]  CATS_RESET    = 7'd64;
    localparam logic [7:0]  TAG_RESET     = 8'd0;

    // One input row
    typedef struct packed {
        logic [5:0]         category;
        logic signed [31:0] response;
        logic               row_masked;
        logic               last_row;
    } t_row;

    // One selection result
    typedef struct packed {
        logic               found;
        logic [5:0]         best_category;
        logic signed [31:0] best_quality;
        logic [16:0]        removed_rows;
        logic [7:0]         column_out;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic row_accept;
        logic row_update;
        logic scan_prep;
        logic scan_read;
        logic scan_check;
        logic best_update;
        logic finish;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic qualify;
        logic scan_end;
        logic last_row;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

### design/cps_divider.sv
// Bit-serial signed divider, one quotient bit per cycle.
// Depends on cps_pkg for house consistency; used by cps_datapath.
module cps_divider #(
    parameter int SW = 49,
    parameter int CW = 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [SW-1:0] i_dividend,
    input  logic [CW-1:0]        i_divisor,
    output logic                 o_done,
    output logic signed [31:0]   o_quotient
);
    import cps_pkg::*;

    localparam int NW = $clog2(SW + 1);

    logic          r_busy, r_done, r_neg;
    logic [NW-1:0] r_cnt;
    logic [SW-1:0] r_dvd;
    logic [CW-1:0] r_rem, r_div;
    logic [CW:0]   rem_sh;
    logic          qbit;
    logic [CW-1:0] n_rem;
    logic [SW-1:0] q_signed;

    // One restoring step
    always_comb begin
        rem_sh = {r_rem, r_dvd[SW-1]};
        qbit   = (rem_sh >= {1'b0, r_div});
        if (qbit) begin
            n_rem = CW'(rem_sh - {1'b0, r_div});
        end else begin
            n_rem = rem_sh[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= NW'(SW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == NW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Operands work on magnitudes; sign restored at the end
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SW-1];
            r_dvd <= i_dividend[SW-1] ? SW'(-i_dividend) : SW'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[SW-2:0], qbit};
        end
    end

    assign q_signed   = r_neg ? SW'(-r_dvd) : r_dvd;
    assign o_quotient = q_signed[31:0];
    assign o_done     = r_done && !r_busy;

endmodule

### design/cps_datapath.sv
// Accumulators, category memory, qualification tests and result register.
// Depends on cps_pkg and cps_divider.
module cps_datapath #(
    parameter int MAX_CATEGORIES = 64,
    parameter int MAX_ROWS       = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cps_pkg::t_cmd    i_cmd,
    output cps_pkg::t_status o_status,
    input  cps_pkg::t_row    i_row,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [16:0]      i_cfg_data,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output cps_pkg::t_result o_out_data
);
    import cps_pkg::*;

    localparam int IW = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1;
    localparam int LW = $clog2(MAX_CATEGORIES + 1);
    localparam int CW = $clog2(MAX_ROWS + 1);
    localparam int SW = 32 + CW;
    localparam int EW = SW + CW;
    localparam int PW = CW + 17;

    // Configuration registers
    logic [16:0] r_alpha, r_support;
    logic [6:0]  r_cats;
    logic [7:0]  r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha   <= ALPHA_RESET;
            r_support <= SUPPORT_RESET;
            r_cats    <= CATS_RESET;
            r_tag     <= TAG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ALPHA:   r_alpha   <= i_cfg_data;
                CFG_SUPPORT: r_support <= i_cfg_data;
                CFG_CATS:    r_cats    <= i_cfg_data[6:0];
                CFG_TAG:     r_tag     <= i_cfg_data[7:0];
            endcase
        end
    end

    // Latched row
    t_row          r_row;
    logic          r_row_in_range;
    logic [IW-1:0] r_row_addr;
    logic [31:0]   cat_ext;

    assign cat_ext = 32'(i_row.category);

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_accept) begin
            r_row          <= i_row;
            r_row_in_range <= (cat_ext < 32'(MAX_CATEGORIES));
            r_row_addr     <= IW'(cat_ext);
        end
    end

    // Category memory: {sum, rows}, with per-entry valid bits
    logic [EW-1:0]             r_mem [MAX_CATEGORIES];
    logic [MAX_CATEGORIES-1:0] r_valid;
    logic [EW-1:0]             r_rd_data;
    logic                      r_rd_valid;
    logic [IW-1:0]             rd_addr;
    logic [LW-1:0]             r_scan;
    logic                      mem_we;
    logic [EW-1:0]             wr_data;

    assign rd_addr = i_cmd.row_accept ? IW'(cat_ext) : r_scan[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_accept || i_cmd.scan_read) begin
            r_rd_data  <= r_mem[rd_addr];
            r_rd_valid <= r_valid[rd_addr];
        end
        if (mem_we) begin
            r_mem[r_row_addr] <= wr_data;
        end
    end

    logic [CW-1:0]        rd_rows;
    logic signed [SW-1:0] rd_sum;

    assign rd_rows = r_rd_valid ? r_rd_data[CW-1:0] : '0;
    assign rd_sum  = r_rd_valid ? signed'(r_rd_data[EW-1:CW]) : '0;

    // Row accumulation
    logic                 accumulate;
    logic signed [SW-1:0] resp_ext;
    logic signed [SW-1:0] r_total;
    logic [CW-1:0]        r_unm, r_all;

    assign accumulate = i_cmd.row_update && (32'(r_all) < 32'(MAX_ROWS));
    assign resp_ext   = SW'(r_row.response);
    assign mem_we     = accumulate && !r_row.row_masked && r_row_in_range;
    assign wr_data    = {SW'(rd_sum + resp_ext), CW'(rd_rows + 1'b1)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_valid <= '0;
            r_total <= '0;
            r_unm   <= '0;
            r_all   <= '0;
        end else if (accumulate) begin
            r_all <= r_all + 1'b1;
            if (!r_row.row_masked) begin
                r_total <= r_total + resp_ext;
                r_unm   <= r_unm + 1'b1;
            end
            if (mem_we) begin
                r_valid[r_row_addr] <= 1'b1;
            end
        end
    end

    // Scan set-up: fixed products and scan limit
    logic [PW-1:0] r_alpha_prod, r_sup_prod;
    logic [LW-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_prep) begin
            r_alpha_prod <= PW'(r_alpha) * PW'(r_unm);
            r_sup_prod   <= PW'(r_support) * PW'(r_all);
            if (32'(r_cats) > 32'(MAX_CATEGORIES)) begin
                r_limit <= LW'(MAX_CATEGORIES);
            end else begin
                r_limit <= LW'(r_cats);
            end
        end
    end

    // Qualification of the category just read
    logic [CW-1:0] keep;
    logic          qualify;

    assign keep    = r_unm - rd_rows;
    assign qualify = (rd_rows != '0) && (rd_rows < r_unm)
                     && (PW'({rd_rows, 16'h0}) < r_alpha_prod)
                     && (PW'({keep, 16'h0}) >= r_sup_prod);

    // Mean of kept rows
    logic               div_done;
    logic signed [31:0] mean;

    cps_divider #(.SW(SW), .CW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.scan_check && qualify),
        .i_dividend (SW'(r_total - rd_sum)),
        .i_divisor  (keep),
        .o_done     (div_done),
        .o_quotient (mean)
    );

    // Best tracking and scan index
    logic               r_have;
    logic signed [31:0] r_best_mean;
    logic [CW-1:0]      r_best_rem, r_removed;
    logic [IW-1:0]      r_best_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_check) begin
            r_removed <= rd_rows;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.scan_prep) begin
            r_have      <= 1'b0;
            r_best_mean <= '0;
            r_best_rem  <= '0;
            r_best_idx  <= '0;
            r_scan      <= '0;
        end else begin
            if (i_cmd.best_update) begin
                if (!r_have || (mean > r_best_mean)
                    || ((mean == r_best_mean) && (r_removed < r_best_rem))) begin
                    r_have      <= 1'b1;
                    r_best_mean <= mean;
                    r_best_rem  <= r_removed;
                    r_best_idx  <= r_scan[IW-1:0];
                end
            end
            if (i_cmd.best_update || (i_cmd.scan_check && !qualify)) begin
                r_scan <= r_scan + 1'b1;
            end
        end
    end

    // Result register
    logic out_free;

    assign out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_out_data.found         <= r_have;
            o_out_data.best_category <= r_have ? 6'(32'(r_best_idx)) : '0;
            o_out_data.best_quality  <= r_have ? r_best_mean : '0;
            o_out_data.removed_rows  <= r_have ? 17'(32'(r_best_rem)) : '0;
            o_out_data.column_out    <= r_tag;
        end
    end

    assign o_status.qualify  = qualify;
    assign o_status.scan_end = (r_scan >= r_limit);
    assign o_status.last_row = r_row.last_row;
    assign o_status.div_done = div_done;
    assign o_status.out_free = out_free;

endmodule

### design/cps_ctrl.sv
// Controller state machine sequencing row updates and the category scan.
// Depends on cps_pkg.
module cps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  cps_pkg::t_status i_status,
    output cps_pkg::t_cmd    o_cmd
);
    import cps_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_UPDATE = 8'b0000_0010,
        S_PREP   = 8'b0000_0100,
        S_READ   = 8'b0000_1000,
        S_CHECK  = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_BEST   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.row_accept = 1'b1;
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.row_update = 1'b1;
                n_state = i_status.last_row ? S_PREP : S_IDLE;
            end
            S_PREP: begin
                o_cmd.scan_prep = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                if (i_status.scan_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_read = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.scan_check = 1'b1;
                n_state = i_status.qualify ? S_DIV : S_READ;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_BEST;
                end
            end
            S_BEST: begin
                o_cmd.best_update = 1'b1;
                n_state = S_READ;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### design/categorical_peel_selector_unit.sv
// Categorical peel selector: row accumulation and best-category selection.
// Depends on cps_pkg, cps_ctrl and cps_datapath.
//
// Rows of one column arrive on the input request channel (i_in_*). Each
// unmasked row adds its response to its category's sum and count. A row
// flagged last_row starts a scan of the categories; one result request then
// leaves on the output channel (o_out_*) carrying the winning category, the
// mean of the kept rows and the removed count. Other rows give no result.
// Each row is read from the category memory and then written back to it;
// the block takes no new row until the write back is done. The scan reads
// and checks each category in turn; each qualifying one also waits for the
// bit-serial divider that forms the mean before the best is updated.
// Configuration writes (o_cfg_ready is always high) go to the registers
// alpha_fraction, min_support, category_count and column_tag by index.
// Reset restores register defaults and clears all accumulators at once via
// per-category valid bits; no clearing pass is needed. A stalled receiver
// holds the result; rows are still taken, but a new result is not stored
// until the old one can be replaced; storing it clears the accumulators.
module categorical_peel_selector_unit #(
    parameter int MAX_CATEGORIES = 64,
    parameter int MAX_ROWS       = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  cps_pkg::t_row    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output cps_pkg::t_result o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [16:0]      i_cfg_data
);
    import cps_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    cps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cps_datapath #(
        .MAX_CATEGORIES (MAX_CATEGORIES),
        .MAX_ROWS       (MAX_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_row       (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
